@@ design/assert_macros.svh @@
// Assertion macros shared by the formatter RTL.
// No dependencies; the assertions drop out when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check prop at every rising edge of clk outside reset.
`define NTAF_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// Check that post holds in the cycle after pre.
`define NTAF_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define NTAF_ASSERT(label, clk, rst, prop, msg)
`define NTAF_ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

@@ design/ntaf_pkg.sv @@
// Package for the number-to-ASCII formatter: field widths, opcodes,
// ASCII codes and the nibble-to-character function. No dependencies.
package ntaf_pkg;

  localparam int OPCODE_W = 4;
  localparam int VALUE_W  = 64;
  localparam int CHAR_W   = 8;

  // Decimal conversion covers the low 32 bits, at most ten digits.
  localparam int DEC_BITS   = 32;
  localparam int DEC_DIGITS = 10;

  localparam logic [OPCODE_W-1:0] OP_DEC   = 4'd0;
  localparam logic [OPCODE_W-1:0] OP_HEX8  = 4'd1;
  localparam logic [OPCODE_W-1:0] OP_HEX16 = 4'd2;
  localparam logic [OPCODE_W-1:0] OP_HEX32 = 4'd3;
  localparam logic [OPCODE_W-1:0] OP_HEX64 = 4'd4;
  localparam logic [OPCODE_W-1:0] OP_BIN8  = 4'd5;
  localparam logic [OPCODE_W-1:0] OP_BIN16 = 4'd6;
  localparam logic [OPCODE_W-1:0] OP_BIN32 = 4'd7;
  localparam logic [OPCODE_W-1:0] OP_BIN64 = 4'd8;

  localparam logic [CHAR_W-1:0] ASCII_0   = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_1   = 8'h31;
  localparam logic [CHAR_W-1:0] ASCII_A   = 8'h41;
  localparam logic [CHAR_W-1:0] ASCII_DOT = 8'h2E;
  localparam logic [CHAR_W-1:0] ASCII_X   = 8'h78;
  localparam logic [CHAR_W-1:0] NUL       = 8'h00;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    logic [CHAR_W-1:0] n8;
    n8 = {4'b0000, nib};
    if (nib < 4'd10) begin
      return ASCII_0 + n8;
    end else begin
      return ASCII_A + n8 - 8'd10;
    end
  endfunction

endpackage

@@ design/ntaf_num_if.sv @@
// Input channel of the formatter: one number with its format opcode.
// Depends on ntaf_pkg.
interface ntaf_num_if;
  import ntaf_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [VALUE_W-1:0]  value;
  logic                leading_prefix;

  modport source (output valid, opcode, value, leading_prefix, input ready);
  modport sink   (input valid, opcode, value, leading_prefix, output ready);
endinterface

@@ design/ntaf_text_if.sv @@
// Output channel of the formatter: up to two ASCII characters per transfer.
// Depends on ntaf_pkg.
interface ntaf_text_if;
  import ntaf_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] first_char;
  logic [CHAR_W-1:0] second_char;
  logic              second_valid;
  logic              last;

  modport source (output valid, first_char, second_char, second_valid, last, input ready);
  modport sink   (input valid, first_char, second_char, second_valid, last, output ready);
endinterface

@@ design/ntaf_dec_conv.sv @@
// Bit-serial binary to BCD converter (shift and add 3), one bit per cycle.
// Depends on ntaf_pkg.
module ntaf_dec_conv (
  input  logic                                         clk,
  input  logic                                         rst,
  input  logic                                         start,
  input  logic [ntaf_pkg::DEC_BITS-1:0]                bin,
  output logic                                         done,
  output logic [4*ntaf_pkg::DEC_DIGITS-1:0]            bcd
);
  import ntaf_pkg::*;

  localparam int CNT_W = $clog2(DEC_BITS);

  logic [DEC_BITS-1:0]     src;
  logic [4*DEC_DIGITS-1:0] acc;
  logic [4*DEC_DIGITS-1:0] adj;
  logic [CNT_W-1:0]        bit_cnt;
  logic                    busy;

  // Correct every digit of five or more before the shift doubles it.
  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      adj[4*i +: 4] = (acc[4*i +: 4] >= 4'd5) ? acc[4*i +: 4] + 4'd3 : acc[4*i +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      bit_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        bit_cnt <= '0;
        src     <= bin;
        acc     <= '0;
      end else if (busy) begin
        acc     <= {adj[4*DEC_DIGITS-2:0], src[DEC_BITS-1]};
        src     <= {src[DEC_BITS-2:0], 1'b0};
        bit_cnt <= bit_cnt + 1'b1;
        if (bit_cnt == CNT_W'(DEC_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign bcd = acc;

endmodule

@@ design/number_to_ascii_formatter_core.sv @@
// Number-to-ASCII formatter: decimal, hex, dotted binary text, up to two chars per transfer.
// Depends on ntaf_pkg, ntaf_num_if, ntaf_text_if, ntaf_dec_conv and assert_macros.svh.
// Hex and binary load one character per cycle, unless the sink holds the output, from the
// cycle after the input transfer; decimal first converts and loads the digits, then skips
// leading zeros and loads the rest. The next input is taken in the cycle after the final load.
// Reset: synchronous, active high; clears the sequencer, pending character and output valid.
module number_to_ascii_formatter_core (
  input  logic  clk,
  input  logic  rst,
  ntaf_num_if.sink    num,
  ntaf_text_if.source text
);
  import ntaf_pkg::*;
  `include "assert_macros.svh"

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  typedef enum logic [1:0] {
    FMT_DEC = 2'd0,
    FMT_HEX = 2'd1,
    FMT_BIN = 2'd2
  } fmt_t;

  state_t state;
  fmt_t   fmt;

  // Character source: digits or bits leave from the top of sh.
  logic [VALUE_W-1:0] sh, sh_next;
  logic [6:0]         cnt, cnt_next;     // digits or bits still to emit
  logic [1:0]         pfx, pfx_next;     // prefix characters still to emit
  logic               dot, dot_next;     // a byte separator is due

  logic [CHAR_W-1:0]  ch;
  logic               ch_last;

  // Pair assembly and output register.
  logic               half;
  logic [CHAR_W-1:0]  half_char;
  logic               tv;
  logic [CHAR_W-1:0]  t_first, t_second;
  logic               t_second_valid, t_last;

  logic               accept, out_free, push_needed, advance;

  logic                     dec_start, dec_done;
  logic [4*DEC_DIGITS-1:0]  dec_bcd;

  assign num.ready = (state == S_IDLE);
  assign accept    = num.valid && num.ready;
  assign dec_start = accept && (num.opcode == OP_DEC);

  ntaf_dec_conv u_dec (
    .clk   (clk),
    .rst   (rst),
    .start (dec_start),
    .bin   (num.value[DEC_BITS-1:0]),
    .done  (dec_done),
    .bcd   (dec_bcd)
  );

  // Pick the next character: prefix first, then a pending dot, then a digit or bit.
  always_comb begin
    ch       = ASCII_0;
    ch_last  = 1'b0;
    sh_next  = sh;
    cnt_next = cnt;
    pfx_next = pfx;
    dot_next = dot;
    if (pfx != 2'd0) begin
      ch       = (pfx == 2'd2) ? ASCII_0 : ASCII_X;
      pfx_next = pfx - 2'd1;
    end else if (dot) begin
      ch       = ASCII_DOT;
      dot_next = 1'b0;
    end else if (fmt == FMT_BIN) begin
      ch       = sh[VALUE_W-1] ? ASCII_1 : ASCII_0;
      sh_next  = {sh[VALUE_W-2:0], 1'b0};
      cnt_next = cnt - 7'd1;
      // A separator follows every byte boundary but the last.
      dot_next = (cnt_next[2:0] == 3'd0) && (cnt_next != 7'd0);
      ch_last  = (cnt == 7'd1);
    end else begin
      // Hex digits and BCD digits share the nibble path.
      ch       = hex_char(sh[VALUE_W-1 -: 4]);
      sh_next  = {sh[VALUE_W-5:0], 4'b0000};
      cnt_next = cnt - 7'd1;
      ch_last  = (cnt == 7'd1);
    end
  end

  // A transfer is built when a pair completes or the text ends.
  assign out_free    = !tv || text.ready;
  assign push_needed = half || ch_last;
  assign advance     = (state == S_EMIT) && (!push_needed || out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fmt   <= FMT_DEC;
      cnt   <= '0;
      pfx   <= '0;
      dot   <= 1'b0;
      half  <= 1'b0;
      tv    <= 1'b0;
    end else begin
      // Drop the output once taken, unless a new transfer is loaded below.
      if (text.ready && !(advance && push_needed)) begin
        tv <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            pfx <= 2'd0;
            dot <= 1'b0;
            case (num.opcode)
              OP_DEC: begin
                fmt   <= FMT_DEC;
                state <= S_CONV;
              end
              OP_HEX8: begin
                sh  <= {num.value[7:0], 56'd0};
                cnt <= 7'd2;
              end
              OP_HEX16: begin
                sh  <= {num.value[15:0], 48'd0};
                cnt <= 7'd4;
              end
              OP_HEX32: begin
                sh  <= {num.value[31:0], 32'd0};
                cnt <= 7'd8;
              end
              OP_HEX64: begin
                sh  <= num.value;
                cnt <= 7'd16;
              end
              OP_BIN8: begin
                sh  <= {num.value[7:0], 56'd0};
                cnt <= 7'd8;
              end
              OP_BIN16: begin
                sh  <= {num.value[15:0], 48'd0};
                cnt <= 7'd16;
              end
              OP_BIN32: begin
                sh  <= {num.value[31:0], 32'd0};
                cnt <= 7'd32;
              end
              OP_BIN64: begin
                sh  <= num.value;
                cnt <= 7'd64;
              end
              default: begin
                // Unused opcode: no text, stay idle.
              end
            endcase
            if (num.opcode inside {[OP_HEX8:OP_HEX64]}) begin
              fmt   <= FMT_HEX;
              pfx   <= num.leading_prefix ? 2'd2 : 2'd0;
              state <= S_EMIT;
            end else if (num.opcode inside {[OP_BIN8:OP_BIN64]}) begin
              fmt   <= FMT_BIN;
              state <= S_EMIT;
            end
          end
        end

        S_CONV: begin
          // Hold until the converter finishes, then place the digits on top.
          if (dec_done) begin
            sh    <= {dec_bcd, {(VALUE_W - 4*DEC_DIGITS){1'b0}}};
            cnt   <= 7'(DEC_DIGITS);
            state <= S_SKIP;
          end
        end

        S_SKIP: begin
          // Drop leading zero digits, keeping at least one.
          if ((sh[VALUE_W-1 -: 4] == 4'd0) && (cnt != 7'd1)) begin
            sh  <= {sh[VALUE_W-5:0], 4'b0000};
            cnt <= cnt - 7'd1;
          end else begin
            state <= S_EMIT;
          end
        end

        S_EMIT: begin
          if (advance) begin
            sh  <= sh_next;
            cnt <= cnt_next;
            pfx <= pfx_next;
            dot <= dot_next;
            if (half) begin
              half           <= 1'b0;
              tv             <= 1'b1;
              t_first        <= half_char;
              t_second       <= ch;
              t_second_valid <= 1'b1;
              t_last         <= ch_last;
            end else if (ch_last) begin
              tv             <= 1'b1;
              t_first        <= ch;
              t_second       <= NUL;
              t_second_valid <= 1'b0;
              t_last         <= 1'b1;
            end else begin
              half      <= 1'b1;
              half_char <= ch;
            end
            if (ch_last) begin
              state <= S_IDLE;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign text.valid        = tv;
  assign text.first_char   = t_first;
  assign text.second_char  = t_second;
  assign text.second_valid = t_second_valid;
  assign text.last         = t_last;

  `NTAF_ASSERT(a_idle_no_half, clk, rst, (state == S_IDLE) |-> !half, "pending char while idle")
  `NTAF_ASSERT(a_emit_cnt, clk, rst,
    ((state == S_EMIT) && (pfx == 2'd0) && !dot) |-> (cnt != 7'd0), "digit emitted with zero count")
  `NTAF_ASSERT(a_dot_bin, clk, rst, dot |-> (fmt == FMT_BIN), "separator outside binary format")
  `NTAF_ASSERT(a_conv_done, clk, rst, dec_done |-> (state == S_CONV), "converter done outside conv")
  `NTAF_ASSERT_NEXT(a_last_push, clk, rst, (advance && ch_last),
    ((state == S_IDLE) && tv && t_last), "final transfer not loaded")

endmodule
